// File: design/sgm3_pkg.sv
`default_nettype none
package sgm3_pkg;

	localparam int MAG_W      = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIMXY_W    = 9;
	localparam int DIMZ_W     = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd2;

	localparam logic KIND_VOXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	localparam logic [1:0] DIR_NEG  = 2'd0;
	localparam logic [1:0] DIR_ZERO = 2'd1;
	localparam logic [1:0] DIR_POS  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAP,
		ST_ACC,
		ST_SQ,
		ST_ROOT,
		ST_WAIT
	} seq_state_t;

endpackage
`default_nettype wire

// File: design/sgm3_cell.sv
`default_nettype none
module sgm3_cell #(
	parameter int RW = 42
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              v_i,
	input  logic [RW-1:0]     rad_i,
	input  logic [RW/2+2:0]   rem_i,
	input  logic [RW/2-1:0]   root_i,
	output logic              v_o,
	output logic [RW-1:0]     rad_o,
	output logic [RW/2+2:0]   rem_o,
	output logic [RW/2-1:0]   root_o
);
	localparam int RB = RW / 2;

	logic [RB+2:0] r2;
	logic [RB+2:0] trial;
	logic          fits;
	logic          v_q;
	logic [RW-1:0] rad_q;
	logic [RB+2:0] rem_q;
	logic [RB-1:0] root_q;

	// bring down the next two radicand bits and try a one digit
	assign r2    = {rem_i[RB:0], rad_i[RW-1:RW-2]};
	assign trial = {1'b0, root_i, 2'b01};
	assign fits  = (r2 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= {rad_i[RW-3:0], 2'b00};
		rem_q  <= fits ? (r2 - trial) : r2;
		root_q <= {root_i[RB-2:0], fits};
	end

	assign v_o    = v_q;
	assign rad_o  = rad_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;

endmodule
`default_nettype wire

// File: design/sgm3_root.sv
`default_nettype none
module sgm3_root #(
	parameter int RW = 42
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_v,
	input  logic [RW-1:0]   rad,
	output logic            out_v,
	output logic [RW/2-1:0] root
);
	localparam int RB = RW / 2;

	logic          v_c    [0:RB];
	logic [RW-1:0] rad_c  [0:RB];
	logic [RB+2:0] rem_c  [0:RB];
	logic [RB-1:0] root_c [0:RB];

	assign v_c[0]    = in_v;
	assign rad_c[0]  = rad;
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar i = 0; i < RB; i++) begin : g_cell
		sgm3_cell #(.RW(RW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_i    (v_c[i]),
			.rad_i  (rad_c[i]),
			.rem_i  (rem_c[i]),
			.root_i (root_c[i]),
			.v_o    (v_c[i+1]),
			.rad_o  (rad_c[i+1]),
			.rem_o  (rem_c[i+1]),
			.root_o (root_c[i+1])
		);
	end

	assign out_v = v_c[RB];
	assign root  = root_c[RB];

endmodule
`default_nettype wire

// File: design/sobel_gradient_magnitude_3d_top.sv
// An item that completes a neighbourhood (or a flush that drains one) starts a result:
// 27 window reads through one read port, a shared squarer, one root cell per result bit.
// Input stalls from then until the result is taken. Items that yield no result are taken
// one per cycle.
// Reset (arst_n, asynchronous): counters, flags and handshakes clear, dimensions go to
// 256 x 256 x 1; the window memory is not cleared and needs no clearing pass.
`default_nettype none
module sobel_gradient_magnitude_3d_top #(
	parameter int MAX_WIDTH   = 256,
	parameter int MAX_HEIGHT  = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               kind,
	input  logic signed [SAMPLE_BITS-1:0]      voxel_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [sgm3_pkg::MAG_W-1:0]         magnitude,
	output logic                               last_voxel,
	input  logic                               cfg_we,
	input  logic [sgm3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sgm3_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import sgm3_pkg::*;

	localparam int D  = 2 * MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 4;
	localparam int AW = $clog2(D);
	localparam int OW = AW + 2;
	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int YW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int DW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 3);
	localparam int G  = SAMPLE_BITS + 6;
	localparam int RW = 2 * SAMPLE_BITS + 10;
	localparam int RB = RW / 2;

	// configuration
	logic [DIMXY_W-1:0] dim_x_q, dim_y_q;
	logic [DIMZ_W-1:0]  dim_z_q;
	logic [XW-1:0]      nx;
	logic [YW-1:0]      ny;
	logic [DIMZ_W-1:0]  nz;
	logic [PW-1:0]      nxny;
	logic [DW-1:0]      lag1;

	// positions
	logic [XW-1:0]      ix_q, ox_q, ix_b;
	logic [YW-1:0]      iy_q, oy_q, iy_b;
	logic [DIMZ_W-1:0]  iz_q, oz_q, iz_b;
	logic               in_done_q, out_done_q;
	logic [DW-1:0]      diff_q, diff_b, diff_inc;
	logic [AW-1:0]      wptr_q, optr_q, wptr_b;

	logic in_acc, restart, voxel_take, voxel_emit, flush_emit, emit;
	logic in_last, o_last;

	// sequencer
	seq_state_t         state_q, state_d;
	logic [1:0]         tx_q, ty_q, tz_q, sq_q;
	logic               tap_last;
	logic               tv_s1;
	logic [1:0]         tx_s1, ty_s1, tz_s1;
	logic signed [SAMPLE_BITS-1:0] rd_s1;
	logic signed [G-1:0] gx_q, gy_q, gz_q;
	logic signed [G-1:0] s_ext, tx_term, ty_term, tz_term, sel;
	logic signed [2*G-1:0] prod_q;
	logic [RW-1:0]      sum_q;
	logic               last_pend_q;

	logic signed [OW-1:0] off, a_raw, a_fix;
	logic [AW-1:0]        rd_addr;

	logic signed [SAMPLE_BITS-1:0] mem [0:D-1];

	logic               root_v;
	logic               root_vo;
	logic [RB-1:0]      root;
	logic [MAG_W+RB-1:0] root_ext;
	logic               out_valid_q, last_q;
	logic [MAG_W-1:0]   mag_q;

	// effective dimensions
	always_comb begin
		if (dim_x_q == '0)
			nx = XW'(1);
		else if (32'(dim_x_q) > MAX_WIDTH)
			nx = XW'(MAX_WIDTH);
		else
			nx = XW'(dim_x_q);
		if (dim_y_q == '0)
			ny = YW'(1);
		else if (32'(dim_y_q) > MAX_HEIGHT)
			ny = YW'(MAX_HEIGHT);
		else
			ny = YW'(dim_y_q);
		nz   = (dim_z_q == '0) ? DIMZ_W'(1) : dim_z_q;
		nxny = PW'(32'(nx) * 32'(ny));
		lag1 = DW'(32'(nxny) + 32'(nx) + 32'd2);
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		restart    = in_done_q && out_done_q;
		voxel_take = in_acc && (kind == KIND_VOXEL) && !(in_done_q && !out_done_q);
		flush_emit = in_acc && (kind == KIND_FLUSH) && in_done_q && !out_done_q;
		diff_b     = restart ? '0 : diff_q;
		diff_inc   = diff_b + DW'(1);
		voxel_emit = voxel_take && (diff_inc >= lag1);
		emit       = voxel_emit || flush_emit;
		wptr_b     = restart ? '0 : wptr_q;
		ix_b       = restart ? '0 : ix_q;
		iy_b       = restart ? '0 : iy_q;
		iz_b       = restart ? '0 : iz_q;
		in_last    = (ix_b == nx - XW'(1)) && (iy_b == ny - YW'(1)) && (iz_b == nz - 16'd1);
		o_last     = (ox_q == nx - XW'(1)) && (oy_q == ny - YW'(1)) && (oz_q == nz - 16'd1);
		tap_last   = (state_q == ST_TAP) && (tx_q == DIR_POS) && (ty_q == DIR_POS)
			&& (tz_q == DIR_POS);
	end

	// configuration and positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q     <= DIMXY_W'(256);
			dim_y_q     <= DIMXY_W'(256);
			dim_z_q     <= DIMZ_W'(1);
			ix_q        <= '0;
			iy_q        <= '0;
			iz_q        <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			oz_q        <= '0;
			in_done_q   <= 1'b0;
			out_done_q  <= 1'b0;
			diff_q      <= '0;
			wptr_q      <= '0;
			optr_q      <= '0;
			last_pend_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_DIM_X || cfg_index == CFG_DIM_Y
				|| cfg_index == CFG_DIM_Z) begin
				if (cfg_index == CFG_DIM_X)
					dim_x_q <= cfg_data[DIMXY_W-1:0];
				if (cfg_index == CFG_DIM_Y)
					dim_y_q <= cfg_data[DIMXY_W-1:0];
				if (cfg_index == CFG_DIM_Z)
					dim_z_q <= cfg_data[DIMZ_W-1:0];
				ix_q       <= '0;
				iy_q       <= '0;
				iz_q       <= '0;
				ox_q       <= '0;
				oy_q       <= '0;
				oz_q       <= '0;
				in_done_q  <= 1'b0;
				out_done_q <= 1'b0;
				diff_q     <= '0;
				wptr_q     <= '0;
				optr_q     <= '0;
			end
		end else if (voxel_take) begin
			wptr_q    <= (32'(wptr_b) == D - 1) ? '0 : wptr_b + AW'(1);
			in_done_q <= in_last;
			diff_q    <= voxel_emit ? diff_b : diff_inc;
			if (ix_b == nx - XW'(1)) begin
				ix_q <= '0;
				if (iy_b == ny - YW'(1)) begin
					iy_q <= '0;
					iz_q <= iz_b + 16'd1;
				end else begin
					iy_q <= iy_b + YW'(1);
					iz_q <= iz_b;
				end
			end else begin
				ix_q <= ix_b + XW'(1);
				iy_q <= iy_b;
				iz_q <= iz_b;
			end
			if (restart) begin
				ox_q       <= '0;
				oy_q       <= '0;
				oz_q       <= '0;
				optr_q     <= '0;
				out_done_q <= 1'b0;
			end
		end else if (flush_emit) begin
			diff_q <= diff_q - DW'(1);
		end else if (tap_last) begin
			// the taps are issued: advance to the next output voxel
			last_pend_q <= o_last;
			out_done_q  <= o_last;
			optr_q      <= (32'(optr_q) == D - 1) ? '0 : optr_q + AW'(1);
			if (ox_q == nx - XW'(1)) begin
				ox_q <= '0;
				if (oy_q == ny - YW'(1)) begin
					oy_q <= '0;
					oz_q <= oz_q + 16'd1;
				end else begin
					oy_q <= oy_q + YW'(1);
				end
			end else begin
				ox_q <= ox_q + XW'(1);
			end
		end
	end

	// neighbour address, clamped at the volume faces
	always_comb begin
		off = '0;
		if (tz_q == DIR_POS && oz_q != nz - 16'd1)
			off = off + OW'(nxny);
		else if (tz_q == DIR_NEG && oz_q != '0)
			off = off - OW'(nxny);
		if (ty_q == DIR_POS && oy_q != ny - YW'(1))
			off = off + OW'(nx);
		else if (ty_q == DIR_NEG && oy_q != '0)
			off = off - OW'(nx);
		if (tx_q == DIR_POS && ox_q != nx - XW'(1))
			off = off + OW'(1);
		else if (tx_q == DIR_NEG && ox_q != '0)
			off = off - OW'(1);
		a_raw = OW'(optr_q) + off;
		if (a_raw < 0)
			a_fix = a_raw + OW'(D);
		else if (a_raw >= OW'(D))
			a_fix = a_raw - OW'(D);
		else
			a_fix = a_raw;
		rd_addr = a_fix[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (voxel_take)
			mem[wptr_b] <= voxel_value;
	end

	always_ff @(posedge clk) begin
		rd_s1 <= mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		root_v  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (emit)
					state_d = ST_TAP;
			end
			ST_TAP: begin
				if (tap_last)
					state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = ST_SQ;
			end
			ST_SQ: begin
				if (sq_q == 2'd3)
					state_d = ST_ROOT;
			end
			ST_ROOT: begin
				root_v  = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (out_valid_q && !out_stall)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q  <= DIR_NEG;
			ty_q  <= DIR_NEG;
			tz_q  <= DIR_NEG;
			sq_q  <= '0;
			tv_s1 <= 1'b0;
		end else begin
			tv_s1 <= (state_q == ST_TAP);
			if (state_q == ST_TAP) begin
				if (tx_q == DIR_POS) begin
					tx_q <= DIR_NEG;
					if (ty_q == DIR_POS) begin
						ty_q <= DIR_NEG;
						tz_q <= (tz_q == DIR_POS) ? DIR_NEG : tz_q + 2'd1;
					end else begin
						ty_q <= ty_q + 2'd1;
					end
				end else begin
					tx_q <= tx_q + 2'd1;
				end
			end
			sq_q <= (state_q == ST_SQ) ? sq_q + 2'd1 : '0;
		end
	end

	// weighted accumulation: derivative on one axis, 1-2-1 on the others
	always_comb begin
		s_ext   = G'(rd_s1);
		tx_term = s_ext <<< (32'(ty_s1 == DIR_ZERO) + 32'(tz_s1 == DIR_ZERO));
		ty_term = s_ext <<< (32'(tx_s1 == DIR_ZERO) + 32'(tz_s1 == DIR_ZERO));
		tz_term = s_ext <<< (32'(tx_s1 == DIR_ZERO) + 32'(ty_s1 == DIR_ZERO));
		case (sq_q)
			2'd0:    sel = gx_q;
			2'd1:    sel = gy_q;
			default: sel = gz_q;
		endcase
	end

	always_ff @(posedge clk) begin
		tx_s1 <= tx_q;
		ty_s1 <= ty_q;
		tz_s1 <= tz_q;
		if (emit) begin
			gx_q <= '0;
			gy_q <= '0;
			gz_q <= '0;
		end else if (tv_s1) begin
			if (tx_s1 == DIR_POS)
				gx_q <= gx_q + tx_term;
			else if (tx_s1 == DIR_NEG)
				gx_q <= gx_q - tx_term;
			if (ty_s1 == DIR_POS)
				gy_q <= gy_q + ty_term;
			else if (ty_s1 == DIR_NEG)
				gy_q <= gy_q - ty_term;
			if (tz_s1 == DIR_POS)
				gz_q <= gz_q + tz_term;
			else if (tz_s1 == DIR_NEG)
				gz_q <= gz_q - tz_term;
		end
		if (state_q == ST_ACC) begin
			prod_q <= '0;
			sum_q  <= '0;
		end else if (state_q == ST_SQ) begin
			prod_q <= sel * sel;
			sum_q  <= sum_q + prod_q[RW-1:0];
		end
	end

	sgm3_root #(.RW(RW)) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.in_v   (root_v),
		.rad    (sum_q),
		.out_v  (root_vo),
		.root   (root)
	);

	assign root_ext = {{MAG_W{1'b0}}, root};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (root_vo) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (root_vo) begin
			mag_q  <= root_ext[MAG_W-1:0];
			last_q <= last_pend_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign magnitude  = mag_q;
	assign last_voxel = last_q;

endmodule
`default_nettype wire

// File: design/sgm3_check.sv
`default_nettype none
module sgm3_check (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [sgm3_pkg::MAG_W-1:0] magnitude,
	input logic                       last_voxel
);
	import sgm3_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(magnitude) && $stable(last_voxel))
		else $error("stalled result item changed");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result item waits");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("second result item without a new input item");

endmodule

bind sobel_gradient_magnitude_3d_top sgm3_check u_sgm3_check (.*);
`default_nettype wire

// File: sim/sgm3_checker.sv
`default_nettype none
module sgm3_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic                            kind,
	input  wire logic signed [15:0]              voxel_value,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic [sgm3_pkg::MAG_W-1:0]      magnitude,
	input  wire logic                            last_voxel,
	input  wire logic                            cfg_we,
	input  wire logic [sgm3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sgm3_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                   fails,
	output int                                   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sgm3_pkg::*;

	localparam int MAX_W = 256;
	localparam int MAX_H = 256;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             last;
	} grad_result_t;

	logic [DIMXY_W-1:0] width_reg, height_reg;
	logic [DIMZ_W-1:0]  depth_reg;
	longint             voxels_in, results_out;
	shortint            volume[longint];
	grad_result_t       grad_q[$];

	function automatic longint extent(longint v, longint hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint edge_clamp(longint c, longint n);
		if (c < 0) return 0;
		if (c >= n) return n - 1;
		return c;
	endfunction

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// work out the gradient at the next output voxel and queue it
	task automatic predict_gradient(longint nx, longint ny, longint nz);
		longint x, y, z, g[3], s, wx, wy, wz, lin;
		grad_result_t res;
		x = results_out % nx;
		y = (results_out / nx) % ny;
		z = results_out / (nx * ny);
		g = '{0, 0, 0};
		for (int dz = -1; dz <= 1; dz++)
			for (int dy = -1; dy <= 1; dy++)
				for (int dx = -1; dx <= 1; dx++) begin
					lin = (edge_clamp(z + dz, nz) * ny + edge_clamp(y + dy, ny)) * nx
						+ edge_clamp(x + dx, nx);
					s = volume[lin];
					wx = (dy == 0 ? 2 : 1) * (dz == 0 ? 2 : 1);
					wy = (dx == 0 ? 2 : 1) * (dz == 0 ? 2 : 1);
					wz = (dx == 0 ? 2 : 1) * (dy == 0 ? 2 : 1);
					g[0] += dx * wx * s;
					g[1] += dy * wy * s;
					g[2] += dz * wz * s;
				end
		res.mag = MAG_W'(int_root(g[0] * g[0] + g[1] * g[1] + g[2] * g[2]));
		res.last = (results_out + 1 == nx * ny * nz);
		grad_q = {grad_q, res};
		results_out++;
	endtask

	task automatic take_item(logic k, shortint v);
		longint nx, ny, nz, total;
		nx = extent(width_reg, MAX_W);
		ny = extent(height_reg, MAX_H);
		nz = extent(depth_reg, 65535);
		total = nx * ny * nz;
		if (k == KIND_VOXEL) begin
			if (voxels_in >= total) begin
				if (results_out < total) return;
				voxels_in = 0;
				results_out = 0;
				volume.delete();
			end
			volume[voxels_in] = v;
			voxels_in++;
			if (results_out < total && voxels_in >= results_out + nx * ny + nx + 2)
				predict_gradient(nx, ny, nz);
		end else if (voxels_in >= total && results_out < total) begin
			predict_gradient(nx, ny, nz);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		grad_result_t exp_r;
		if (!arst_n) begin
			width_reg = 256;
			height_reg = 256;
			depth_reg = 1;
			voxels_in = 0;
			results_out = 0;
			volume.delete();
			grad_q.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DIM_X: width_reg = cfg_data[DIMXY_W-1:0];
					CFG_DIM_Y: height_reg = cfg_data[DIMXY_W-1:0];
					CFG_DIM_Z: depth_reg = cfg_data[DIMZ_W-1:0];
					default: ;
				endcase
				if (cfg_index == CFG_DIM_X || cfg_index == CFG_DIM_Y ||
				    cfg_index == CFG_DIM_Z) begin
					voxels_in = 0;
					results_out = 0;
					volume.delete();
				end
			end
			if (in_valid && !in_stall)
				take_item(kind, voxel_value);
			if (out_valid && !out_stall) begin
				if (grad_q.size() == 0) begin
					$error("unexpected result: magnitude %0d last_voxel %0b",
						magnitude, last_voxel);
					fails++;
				end else begin
					exp_r = grad_q.pop_front();
					if (magnitude !== exp_r.mag) begin
						$error("magnitude: expected %0d, got %0d", exp_r.mag, magnitude);
						fails++;
					end
					if (last_voxel !== exp_r.last) begin
						$error("last_voxel: expected %0b, got %0b", exp_r.last, last_voxel);
						fails++;
					end
				end
			end
			pending = grad_q.size();
		end
	end

endmodule
`default_nettype wire

// File: sim/tb_sobel_gradient_magnitude_3d_top.sv
`default_nettype none
module tb_sobel_gradient_magnitude_3d_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sgm3_pkg::*;

	logic                  clk, arst_n;
	logic                  in_valid, in_stall, kind;
	logic signed [15:0]    voxel_value;
	logic                  out_valid, out_stall, last_voxel;
	logic [MAG_W-1:0]      magnitude;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fails, pending;
	int                    items_sent;
	bit                    no_gaps;

	sobel_gradient_magnitude_3d_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .voxel_value(voxel_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.magnitude(magnitude), .last_voxel(last_voxel),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sgm3_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .voxel_value(voxel_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.magnitude(magnitude), .last_voxel(last_voxel),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("sobel_gradient_magnitude_3d_top regression: fail");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver back-pressure, with quiet stretches
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 9) == 0) begin
				out_stall = 0;
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end else begin
				out_stall = 1;
				repeat (idle_len()) @(negedge clk);
				out_stall = 0;
			end
		end
	end

	task automatic send(logic k, logic signed [15:0] v);
		if (!no_gaps)
			repeat (idle_len()) @(negedge clk);
		in_valid = 1;
		kind = k;
		voxel_value = v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 0;
		kind = 1'($urandom_range(0, 1));
		voxel_value = 16'($urandom);
		items_sent++;
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic set_dims(int x, int y, int z);
		drain();
		cfg_we = 1;
		cfg_index = CFG_DIM_X; cfg_data = CFG_DATA_W'(x);
		@(negedge clk);
		cfg_index = CFG_DIM_Y; cfg_data = CFG_DATA_W'(y);
		@(negedge clk);
		cfg_index = CFG_DIM_Z; cfg_data = CFG_DATA_W'(z);
		@(negedge clk);
		cfg_we = 0;
	endtask

	function automatic logic signed [15:0] sample(int mode, int i);
		case (mode)
			0: return 16'($urandom);
			1: return (i % 2) ? 16'sh7FFF : 16'sh8000;
			2: return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
			default: return 16'(16'sh0123 + i);
		endcase
	endfunction

	// fill a volume, poke the pending state, then flush it out
	task automatic run_volume(int n, int mode);
		send(KIND_FLUSH, 16'($urandom));
		for (int i = 0; i < n; i++) begin
			if (i == n / 2 && $urandom_range(0, 3) == 0)
				while (pending != 0) @(negedge clk);
			send(KIND_VOXEL, sample(mode, i));
		end
		send(KIND_VOXEL, 16'($urandom));
		for (int i = 0; i < n + 1; i++)
			send(KIND_FLUSH, 16'($urandom));
	endtask

	initial begin
		int nx, ny, nz;
		arst_n = 0;
		in_valid = 0;
		kind = KIND_VOXEL;
		voxel_value = 0;
		cfg_we = 0;
		cfg_index = CFG_DIM_X;
		cfg_data = 0;
		items_sent = 0;
		no_gaps = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// zero dimensions act as one voxel
		set_dims(0, 0, 0);
		run_volume(1, 1);
		set_dims(3, 3, 2);
		run_volume(18, 1);
		// widest row, more than MAX_WIDTH allows
		set_dims(511, 1, 1);
		no_gaps = 1;
		run_volume(256, 2);
		no_gaps = 0;
		// deepest volume: a partial one, abandoned by the next write
		set_dims(1, 1, 65535);
		for (int i = 0; i < 20; i++) send(KIND_VOXEL, sample(0, i));
		set_dims(2, 300, 1);
		for (int i = 0; i < 12; i++) send(KIND_VOXEL, sample(1, i));
		set_dims(2, 2, 3);
		while (pending != 0) @(negedge clk);
		run_volume(12, 2);

		while (items_sent < 860) begin
			nx = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(1, 6);
			ny = $urandom_range(1, 6);
			nz = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 5);
			set_dims(nx, ny, nz);
			no_gaps = $urandom_range(0, 4) == 0;
			run_volume((nx == 0 ? 1 : nx) * ny * (nz == 0 ? 1 : nz), $urandom_range(0, 3));
		end
		no_gaps = 0;
		drain();
		if (fails == 0)
			$display("sobel_gradient_magnitude_3d_top regression: pass");
		else
			$display("sobel_gradient_magnitude_3d_top regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
